### hw/rtl/skya_pkg.sv
// Shared types for the skyline atlas allocator: controller states, command and status bundles.
`timescale 1ns / 1ps

package skya_pkg;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_P1,
    ST_P1_DRAIN,
    ST_P2,
    ST_P2_DRAIN,
    ST_DECIDE,
    ST_WRITE,
    ST_RESULT
  } skya_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic sweep_step;
    logic load_req;
    logic p1_issue;
    logic p2_start;
    logic p2_issue;
    logic next_page;
    logic wb_start;
    logic wb_step;
    logic res_ok;
    logic res_full;
    logic res_clear;
  } skya_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;
    logic reject;
    logic k_zero;
    logic k_end;
    logic fits;
    logic last_page;
    logic wb_last;
  } skya_status_t;

endpackage

### hw/rtl/skya_ctrl.sv
// Controller state machine for the skyline atlas allocator.
`timescale 1ns / 1ps

module skya_ctrl
  import skya_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         command,
  input  skya_status_t st,
  output skya_cmd_t    cmd,
  output logic         busy,
  output logic         done
);

  skya_state_t state;
  skya_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    done       = (state == ST_RESULT);
    unique case (state)
      ST_INIT: begin
        cmd.sweep_step = 1'b1;
        if (st.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load_req = 1'b1;
          if (command) begin
            state_next = ST_CLEAR;
          end else if (st.reject) begin
            cmd.res_full = 1'b1;
            state_next   = ST_RESULT;
          end else begin
            state_next = ST_P1;
          end
        end
      end
      ST_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (st.sweep_last) begin
          cmd.res_clear = 1'b1;
          state_next    = ST_RESULT;
        end
      end
      ST_P1: begin
        cmd.p1_issue = 1'b1;
        if (st.k_zero) begin
          state_next = ST_P1_DRAIN;
        end
      end
      ST_P1_DRAIN: begin
        cmd.p2_start = 1'b1;
        state_next   = ST_P2;
      end
      ST_P2: begin
        cmd.p2_issue = 1'b1;
        if (st.k_end) begin
          state_next = ST_P2_DRAIN;
        end
      end
      ST_P2_DRAIN: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (st.fits) begin
          cmd.wb_start = 1'b1;
          state_next   = ST_WRITE;
        end else if (st.last_page) begin
          cmd.res_full = 1'b1;
          state_next   = ST_RESULT;
        end else begin
          cmd.next_page = 1'b1;
          state_next    = ST_P1;
        end
      end
      ST_WRITE: begin
        cmd.wb_step = 1'b1;
        if (st.wb_last) begin
          cmd.res_ok = 1'b1;
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

### hw/rtl/skya_dpath.sv
// Datapath: column height memory, block-suffix scratch memory, window-max search and write-back.
`timescale 1ns / 1ps

module skya_dpath
  import skya_pkg::*;
#(
  parameter int PAGE_COUNT  = 2,
  parameter int PAGE_WIDTH  = 256,
  parameter int PAGE_HEIGHT = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [8:0]   rect_width,
  input  logic [8:0]   rect_height,
  input  skya_cmd_t    cmd,
  output skya_status_t st,
  output logic         atlas_full,
  output logic         page_index,
  output logic [7:0]   x_pos,
  output logic [7:0]   y_pos
);

  localparam int Total = PAGE_COUNT * PAGE_WIDTH;
  localparam int AW    = $clog2(Total);
  localparam int CW    = $clog2(PAGE_WIDTH);
  localparam int HW    = $clog2(PAGE_HEIGHT + 1);
  localparam int PGW   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int SW    = ((HW > 9) ? HW : 9) + 1;

  localparam logic [12:0]   PwVal   = 13'(PAGE_WIDTH);
  localparam logic [CW-1:0] ColLast = CW'(PAGE_WIDTH - 1);
  localparam logic [CW-1:0] ColEnd  = CW'(PAGE_WIDTH - 2);
  localparam logic [AW-1:0] AddrEnd = AW'(Total - 1);
  localparam logic [HW-1:0] HeightMax = HW'(PAGE_HEIGHT);
  localparam logic [SW-1:0] HeightLim = SW'(PAGE_HEIGHT);

  // Memories
  logic [HW-1:0] heights [Total];
  logic [HW-1:0] sfx     [PAGE_WIDTH];

  // Sweep, page and scan control
  logic [AW-1:0]  sc;
  logic [AW-1:0]  base;
  logic [PGW-1:0] page;
  logic [CW-1:0]  k;
  logic [CW-1:0]  cnt;
  logic [CW-1:0]  cfin;
  logic [CW-1:0]  w_len;
  logic [CW-1:0]  wm1;
  logic [8:0]     h_len;

  // Read pipeline
  logic           p1v;
  logic           p2v;
  logic [CW-1:0]  k1;
  logic           cz1;
  logic           rst2;
  logic           win2;
  logic [HW-1:0]  h_q;
  logic [HW-1:0]  sfx_q;
  logic [HW-1:0]  s_reg;
  logic [HW-1:0]  p_reg;

  // Search result and write-back
  logic [HW-1:0]  best;
  logic [CW-1:0]  best_x;
  logic           found;
  logic [AW-1:0]  wa;
  logic [CW-1:0]  n;

  logic [AW-1:0]  rd_addr;
  logic [CW-1:0]  sfx_ra;
  logic           win;
  logic           h_we;
  logic [AW-1:0]  h_wa;
  logic [HW-1:0]  h_wd;
  logic [SW-1:0]  sum;
  logic [HW-1:0]  s_new;
  logic [HW-1:0]  p_new;
  logic [HW-1:0]  top;

  assign rd_addr = base + AW'(k);
  assign win     = (k >= wm1);
  assign sfx_ra  = win ? (k - wm1) : '0;
  assign sum     = SW'(best) + SW'(h_len);
  assign h_we    = cmd.sweep_step | cmd.wb_step;
  assign h_wa    = cmd.sweep_step ? sc : wa;
  assign h_wd    = cmd.sweep_step ? '0 : HW'(sum);

  assign s_new = (cz1 || (h_q > s_reg)) ? h_q : s_reg;
  assign p_new = (rst2 || (h_q > p_reg)) ? h_q : p_reg;
  assign top   = (sfx_q > p_new) ? sfx_q : p_new;

  always_comb begin
    st.sweep_last = (sc == AddrEnd);
    st.reject     = (rect_width == 9'd0) || (rect_height == 9'd0) ||
                    ({4'b0, rect_width} >= PwVal);
    st.k_zero     = (k == '0);
    st.k_end      = (k == ColEnd);
    st.fits       = found && (sum <= HeightLim);
    st.last_page  = (page == PGW'(PAGE_COUNT - 1));
    st.wb_last    = (n == CW'(1));
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      heights[h_wa] <= h_wd;
    end
    h_q <= heights[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (p1v) begin
      sfx[k1] <= s_new;
    end
    sfx_q <= sfx[sfx_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sc  <= '0;
      p1v <= 1'b0;
      p2v <= 1'b0;
    end else begin
      if (cmd.sweep_step) begin
        sc <= st.sweep_last ? '0 : sc + AW'(1);
      end
      p1v <= cmd.p1_issue;
      p2v <= cmd.p2_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      w_len <= CW'(rect_width);
      wm1   <= CW'(rect_width) - CW'(1);
      h_len <= rect_height;
      page  <= '0;
      base  <= '0;
      k     <= ColLast;
      cnt   <= '0;
    end
    if (cmd.next_page) begin
      page <= page + PGW'(1);
      base <= base + AW'(PAGE_WIDTH);
      k    <= ColLast;
      cnt  <= '0;
    end

    // Pass one: descend the page, count position within block from the top.
    if (cmd.p1_issue) begin
      k   <= k - CW'(1);
      cnt <= (cnt == wm1) ? '0 : cnt + CW'(1);
      if (k == '0) begin
        cfin <= cnt;
      end
      k1  <= k;
      cz1 <= (cnt == '0);
    end
    if (p1v) begin
      s_reg <= s_new;
    end

    // Pass two: ascend, build block prefix max and combine with stored suffix max.
    if (cmd.p2_start) begin
      k     <= '0;
      cnt   <= cfin;
      best  <= HeightMax;
      found <= 1'b0;
    end
    if (cmd.p2_issue) begin
      k    <= k + CW'(1);
      cnt  <= (cnt == '0) ? wm1 : cnt - CW'(1);
      k1   <= k;
      rst2 <= (cnt == wm1) || (k == '0);
      win2 <= win;
    end
    if (p2v) begin
      p_reg <= p_new;
      if (win2 && (top < best)) begin
        best   <= top;
        best_x <= k1 - wm1;
        found  <= 1'b1;
      end
    end

    // Raise the chosen columns.
    if (cmd.wb_start) begin
      wa <= base + AW'(best_x);
      n  <= w_len;
    end
    if (cmd.wb_step) begin
      wa <= wa + AW'(1);
      n  <= n - CW'(1);
    end

    if (cmd.res_ok) begin
      atlas_full <= 1'b0;
      page_index <= page[0];
      x_pos      <= 8'(best_x);
      y_pos      <= 8'(best);
    end else if (cmd.res_full || cmd.res_clear) begin
      atlas_full <= cmd.res_full;
      page_index <= 1'b0;
      x_pos      <= '0;
      y_pos      <= '0;
    end
  end

endmodule

### hw/rtl/skyline_atlas_allocator.sv
// Top level of the skyline atlas allocator: controller and datapath.
`timescale 1ns / 1ps

// Places rectangles into PAGE_COUNT pages of PAGE_WIDTH x PAGE_HEIGHT texels
// along a per-column skyline. An item is taken when start is high and busy
// low; its one result appears on atlas_full, page_index, x_pos and y_pos for
// the single cycle that done is high, and must be captured then. The outputs
// are registered and hold until the next result. After reset the column
// heights are zeroed one entry a cycle, all PAGE_COUNT * PAGE_WIDTH entries,
// with busy high. A clear item zeros them again, and a rejected allocate item
// (zero size, or width not below PAGE_WIDTH) goes straight to its result.
// Otherwise the pages are tried in order, a placed rectangle raises its w
// columns, and atlas_full is set when no page holds it. The search is set by
// the single read port of the column height memory, which is swept once
// downward and once upward per page. busy drops the cycle after done, so the
// next item is taken in the cycle after a result at the earliest.
module skyline_atlas_allocator
  import skya_pkg::*;
#(
  parameter int PAGE_COUNT  = 2,
  parameter int PAGE_WIDTH  = 256,
  parameter int PAGE_HEIGHT = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       command,
  input  logic [8:0] rect_width,
  input  logic [8:0] rect_height,
  output logic       done,
  output logic       atlas_full,
  output logic       page_index,
  output logic [7:0] x_pos,
  output logic [7:0] y_pos
);

  skya_cmd_t    cmd;
  skya_status_t st;

  skya_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .st      (st),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done)
  );

  skya_dpath #(
    .PAGE_COUNT  (PAGE_COUNT),
    .PAGE_WIDTH  (PAGE_WIDTH),
    .PAGE_HEIGHT (PAGE_HEIGHT)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .cmd         (cmd),
    .st          (st),
    .atlas_full  (atlas_full),
    .page_index  (page_index),
    .x_pos       (x_pos),
    .y_pos       (y_pos)
  );

endmodule

### hw/rtl/skya_checker.sv
// Port-level checks for the skyline atlas allocator, bound to the top level.
`timescale 1ns / 1ps

module skya_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       atlas_full,
  input logic       page_index,
  input logic [7:0] x_pos,
  input logic [7:0] y_pos
);

  // A result only comes out of work in progress.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");

  // An accepted item keeps the block busy next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("not busy after accepting an item");

  // One result per item: the result strobe is never held.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");

  // A full result carries no placement.
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (done && atlas_full) |-> (page_index == 1'b0 && x_pos == 8'd0 && y_pos == 8'd0))
    else $error("full result with nonzero placement");

endmodule

bind skyline_atlas_allocator skya_checker u_skya_checker (.*);

### tb/tb_skyline_atlas_allocator.sv
// Self-checking testbench for the skyline atlas allocator: directed and random placement items.
`timescale 1ns / 1ps

module tb_skyline_atlas_allocator;

  localparam int PAGES  = 2;
  localparam int PAGE_W = 256;
  localparam int PAGE_H = 256;

  localparam bit CMD_ALLOC = 1'b0;
  localparam bit CMD_CLEAR = 1'b1;

  localparam int TARGET_ITEMS = 1000;
  localparam int STALL_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 1400;

  typedef struct packed {
    logic       cmd;
    logic [8:0] w;
    logic [8:0] h;
    logic       drain;
  } request_t;

  typedef struct packed {
    logic       full;
    logic       page;
    logic [7:0] x;
    logic [7:0] y;
  } placement_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic       command = CMD_ALLOC;
  logic [8:0] rect_width = 9'd1;
  logic [8:0] rect_height = 9'd1;
  logic       done;
  logic       atlas_full;
  logic       page_index;
  logic [7:0] x_pos;
  logic [7:0] y_pos;

  request_t   request_q[$];
  placement_t placement_q[$];
  bit [8:0]   skyline[PAGES * PAGE_W];

  int sent_cnt = 0;
  int taken_cnt = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int burst_left = 1;
  int err_count = 0;
  bit timed_out = 1'b0;

  skyline_atlas_allocator #(
    .PAGE_COUNT (PAGES),
    .PAGE_WIDTH (PAGE_W),
    .PAGE_HEIGHT(PAGE_H)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .rect_width (rect_width),
    .rect_height(rect_height),
    .done       (done),
    .atlas_full (atlas_full),
    .page_index (page_index),
    .x_pos      (x_pos),
    .y_pos      (y_pos)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Lowest-skyline placement over the pages in order; updates the column heights.
  function automatic placement_t place_rect(logic cmd, logic [8:0] w, logic [8:0] h);
    placement_t r;
    int p, i, j, top, best, best_x, base, wi, hi;
    bit found;
    r = '0;
    wi = int'(w);
    hi = int'(h);
    if (cmd == CMD_CLEAR) begin
      foreach (skyline[k]) skyline[k] = '0;
      return r;
    end
    r.full = 1'b1;
    if (wi == 0 || hi == 0) return r;
    for (p = 0; p < PAGES; p++) begin
      if (wi < PAGE_W) begin
        best = PAGE_H;
        best_x = 0;
        found = 1'b0;
        base = p * PAGE_W;
        for (i = 0; i < PAGE_W - wi; i++) begin
          top = 0;
          for (j = 0; j < wi && top < best; j++) begin
            if (int'(skyline[base + i + j]) > top) top = int'(skyline[base + i + j]);
          end
          if (top < best) begin
            best = top;
            best_x = i;
            found = 1'b1;
          end
        end
        if (found && best + hi <= PAGE_H) begin
          for (j = 0; j < wi; j++) skyline[base + best_x + j] = 9'(best + hi);
          r.full = 1'b0;
          r.page = 1'(p);
          r.x = 8'(best_x);
          r.y = 8'(best);
          return r;
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [8:0] want, logic [8:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  task automatic queue_item(logic cmd, logic [8:0] w, logic [8:0] h, logic drain);
    request_q.push_back('{cmd: cmd, w: w, h: h, drain: drain});
  endtask

  // Size draw per segment style; a few rejects (zero or full page width) mixed in.
  function automatic logic [8:0] rand_size(int mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) return 9'd0;
    if (roll < 4) return 9'd256;
    case (mode)
      0: return 9'($urandom_range(1, 16));
      1: return 9'($urandom_range(1, 64));
      default: begin
        if (roll < 70) return 9'($urandom_range(1, 32));
        if (roll < 95) return 9'($urandom_range(33, 200));
        return 9'($urandom_range(201, 256));
      end
    endcase
  endfunction

  // Sender: bursts of items separated by random gaps; hold each item until taken.
  always @(negedge clk) begin : drive_blk
    request_t req;
    if (rst) begin
      start <= 1'b0;
    end else if (start && taken_cnt != sent_cnt) begin
      // hold
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (request_q.size() == 0 ||
                 (request_q[0].drain && placement_q.size() != 0)) begin
      start <= 1'b0;
    end else begin
      req = request_q.pop_front();
      command <= req.cmd;
      rect_width <= req.w;
      rect_height <= req.h;
      start <= 1'b1;
      sent_cnt <= sent_cnt + 1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 12);
        case ($urandom_range(0, 3))
          0: gap_left <= 0;
          1: gap_left <= $urandom_range(0, 1500);
          default: gap_left <= $urandom_range(0, 20);
        endcase
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // Check results first, then predict for an item taken at the same edge.
  always @(posedge clk) begin
    placement_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (done) begin
        if (placement_q.size() == 0) begin
          $error("result with no item outstanding: full=%0d page=%0d x=%0d y=%0d",
                 atlas_full, page_index, x_pos, y_pos);
          err_count++;
        end else begin
          want = placement_q.pop_front();
          check_field("atlas_full", 9'(want.full), 9'(atlas_full));
          check_field("page_index", 9'(want.page), 9'(page_index));
          check_field("x_pos", 9'(want.x), 9'(x_pos));
          check_field("y_pos", 9'(want.y), 9'(y_pos));
        end
      end
      if (start && !busy) begin
        placement_q.push_back(place_rect(command, rect_width, rect_height));
        taken_cnt <= taken_cnt + 1;
      end
      idle_cycles <= (done || (start && !busy)) ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    int total, seg_len, mode, n;

    // Directed: rejects, fills to the page height, spill to the next page, no room.
    queue_item(CMD_CLEAR, 9'h1FF, 9'h1FF, 1'b0);
    queue_item(CMD_ALLOC, 9'd0, 9'd5, 1'b0);
    queue_item(CMD_ALLOC, 9'd5, 9'd0, 1'b0);
    queue_item(CMD_ALLOC, 9'd256, 9'd1, 1'b0);
    queue_item(CMD_ALLOC, 9'd1, 9'd1, 1'b0);
    queue_item(CMD_ALLOC, 9'd255, 9'd1, 1'b0);
    queue_item(CMD_CLEAR, 9'd0, 9'd0, 1'b0);
    queue_item(CMD_ALLOC, 9'd255, 9'd256, 1'b0);
    queue_item(CMD_ALLOC, 9'd1, 9'd1, 1'b0);
    queue_item(CMD_ALLOC, 9'd255, 9'd256, 1'b0);
    queue_item(CMD_ALLOC, 9'd1, 9'd255, 1'b0);
    queue_item(CMD_ALLOC, 9'd128, 9'd200, 1'b0);
    queue_item(CMD_ALLOC, 9'd128, 9'd56, 1'b0);
    queue_item(CMD_ALLOC, 9'd128, 9'd57, 1'b0);
    queue_item(CMD_ALLOC, 9'd16, 9'd16, 1'b0);
    queue_item(CMD_CLEAR, 9'd0, 9'd0, 1'b0);
    queue_item(CMD_ALLOC, 9'd256, 9'd256, 1'b0);
    queue_item(CMD_ALLOC, 9'd1, 9'd256, 1'b0);
    queue_item(CMD_ALLOC, 9'd254, 9'd255, 1'b0);
    total = request_q.size();

    // Random: segments that start from an empty atlas and fill it up, often to full.
    while (total < TARGET_ITEMS) begin
      queue_item(CMD_CLEAR, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                 total == request_q.size());
      seg_len = $urandom_range(20, 250);
      mode = $urandom_range(0, 2);
      for (n = 0; n < seg_len && total < TARGET_ITEMS; n++) begin
        queue_item(CMD_ALLOC, rand_size(mode), rand_size(mode), $urandom_range(0, 99) == 0);
        total++;
      end
      total++;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    fork
      begin
        while (request_q.size() != 0 || taken_cnt != sent_cnt || placement_q.size() != 0)
          @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
      end
      begin
        while (idle_cycles < STALL_LIMIT) @(posedge clk);
        timed_out = 1'b1;
        $error("watchdog: no progress for %0d cycles", STALL_LIMIT);
      end
    join_any

    if (!timed_out && err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
